// ----- rtl/core/sst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Signal slot table package
// Sizes, codes, state machine states and the structs shared by the core.
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int SLOT_COUNT  = 32;
   localparam int WAITER_BITS = 16;
   localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
   localparam int LEN_BITS    = $clog2(SLOT_COUNT + 1);

   typedef enum logic [1:0] {
      OP_ALLOCATE = 2'd0,
      OP_SIGNAL   = 2'd1,
      OP_RELEASE  = 2'd2,
      OP_GATHER   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_UNUSED   = 2'd0,
      ST_ARMED    = 2'd1,
      ST_SIGNALED = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      RSP_OK       = 2'd0,
      RSP_FULL     = 2'd1,
      RSP_BAD_SLOT = 2'd2
   } rsp_status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_CHECK,
      CS_ALLOC_SCAN,
      CS_TRIM,
      CS_GATHER,
      CS_REPLY
   } ctrl_state_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [SLOT_BITS-1:0]   slot_index;
      logic [WAITER_BITS-1:0] waiter_id;
   } req_word_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]   slot_out;
      logic [WAITER_BITS-1:0] waiter_out;
      logic [LEN_BITS-1:0]    gathered_count;
      rsp_status_type         status_code;
      logic                   any_waiting;
      logic                   last;
   } rsp_word_type;

   typedef struct packed {
      logic                 rd_en;
      logic [SLOT_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_addr;
      slot_state_type       wr_state;
   } status_mem_req_type;

   typedef struct packed {
      logic                   rd_en;
      logic [SLOT_BITS-1:0]   rd_addr;
      logic                   wr_en;
      logic [SLOT_BITS-1:0]   wr_addr;
      logic [WAITER_BITS-1:0] wr_data;
   } waiter_mem_req_type;

endpackage
`default_nettype wire

// ----- rtl/core/sst_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Signal slot table channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface sst_req_if import sst_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             opcode;
   logic [SLOT_BITS-1:0]   slot_index;
   logic [WAITER_BITS-1:0] waiter_id;

   modport source (output valid, output opcode, output slot_index, output waiter_id,
                   input ready);
   modport sink (input valid, input opcode, input slot_index, input waiter_id,
                 output ready);
endinterface

interface sst_rsp_if import sst_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SLOT_BITS-1:0]   slot_out;
   logic [WAITER_BITS-1:0] waiter_out;
   logic [LEN_BITS-1:0]    gathered_count;
   logic [1:0]             status_code;
   logic                   any_waiting;
   logic                   last;

   modport source (output valid, output slot_out, output waiter_out,
                   output gathered_count, output status_code, output any_waiting,
                   output last, input ready);
   modport sink (input valid, input slot_out, input waiter_out, input gathered_count,
                 input status_code, input any_waiting, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/signal_slot_table_core.sv -----
`default_nettype none
// Allocate searches upward for the next free slot and release trims the length downward;
// gathered words stream out during the gather walk. Throughput: one request at a time;
// the slot state memory port walks one entry a cycle, holding while a gathered word waits.
// Reset clears the length, the first-free pointer and the per-slot valid flags at once,
// so all slots read as unused; waiter ids are not cleared and no clearing pass is run.
// ----------------------------------------------------------------------------
// Signal slot table core
// Slot table of completion signals with allocate, signal, release and gather.
// ----------------------------------------------------------------------------
module signal_slot_table_core import sst_pkg::*; (
   input logic      clock,
   input logic      reset,
   sst_req_if.sink  req_ch,
   sst_rsp_if.source rsp_ch
);

   req_word_type           req_word;
   logic                   ctrl_req_ready;
   logic                   out_valid;
   rsp_word_type           out_word;
   logic                   out_ready;
   status_mem_req_type     status_req;
   slot_state_type         status_rd;
   waiter_mem_req_type     waiter_req;
   logic [WAITER_BITS-1:0] waiter_rd;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   assign req_word.opcode     = opcode_type'(req_ch.opcode);
   assign req_word.slot_index = req_ch.slot_index;
   assign req_word.waiter_id  = req_ch.waiter_id;
   assign req_ch.ready        = ctrl_req_ready && !reset;

   sst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_word   (req_word),
      .req_ready  (ctrl_req_ready),
      .out_valid  (out_valid),
      .out_word   (out_word),
      .out_ready  (out_ready),
      .status_req (status_req),
      .status_rd  (status_rd),
      .waiter_req (waiter_req),
      .waiter_rd  (waiter_rd)
   );

   sst_status_mem u_status_mem (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (status_req),
      .rd_state (status_rd)
   );

   sst_waiter_mem u_waiter_mem (
      .clock   (clock),
      .mem_req (waiter_req),
      .rd_data (waiter_rd)
   );

   assign out_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_valid && out_ready) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = out_word;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.slot_out       = rsp_word_ff.slot_out;
   assign rsp_ch.waiter_out     = rsp_word_ff.waiter_out;
   assign rsp_ch.gathered_count = rsp_word_ff.gathered_count;
   assign rsp_ch.status_code    = rsp_word_ff.status_code;
   assign rsp_ch.any_waiting    = rsp_word_ff.any_waiting;
   assign rsp_ch.last           = rsp_word_ff.last;

endmodule
`default_nettype wire

// ----- rtl/core/sst_status_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Slot state memory
// One write and one registered read per cycle. A flag per entry, cleared by
// reset, makes entries that were never written read as unused.
// ----------------------------------------------------------------------------
module sst_status_mem import sst_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  status_mem_req_type mem_req,
   output slot_state_type     rd_state
);

   slot_state_type        state_mem_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff;
   slot_state_type        rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         state_mem_ff[mem_req.wr_addr] <= mem_req.wr_state;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= state_mem_ff[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_state = rd_valid_ff ? rd_data_ff : ST_UNUSED;

endmodule
`default_nettype wire

// ----- rtl/core/sst_waiter_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Waiter id memory
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module sst_waiter_mem import sst_pkg::*; (
   input  logic                   clock,
   input  waiter_mem_req_type     mem_req,
   output logic [WAITER_BITS-1:0] rd_data
);

   logic [WAITER_BITS-1:0] waiter_mem_ff [SLOT_COUNT];
   logic [WAITER_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         waiter_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= waiter_mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/sst_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Signal slot table controller
// Decodes request words and walks the slot memories one entry per cycle, held
// on output stalls in gather; keeps the in-use length and first-free pointer.
// ----------------------------------------------------------------------------
module sst_ctrl import sst_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  req_word_type           req_word,
   output logic                   req_ready,
   output logic                   out_valid,
   output rsp_word_type           out_word,
   input  logic                   out_ready,
   output status_mem_req_type     status_req,
   input  slot_state_type         status_rd,
   output waiter_mem_req_type     waiter_req,
   input  logic [WAITER_BITS-1:0] waiter_rd
);

   ctrl_state_type       state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic [LEN_BITS-1:0]  used_ff, used_in;
   logic [LEN_BITS-1:0]  free_ff, free_in;
   logic [LEN_BITS-1:0]  iss_ff, iss_in;
   logic                 live_ff, live_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [SLOT_BITS-1:0] chk_addr_ff, chk_addr_in;
   logic [LEN_BITS-1:0]  count_ff, count_in;
   logic                 found_ff, found_in;
   logic [SLOT_BITS-1:0] lowest_ff, lowest_in;
   logic [LEN_BITS-1:0]  keep_ff, keep_in;
   rsp_word_type         word_ff, word_in;

   logic                alloc_full;
   logic [LEN_BITS-1:0] alloc_next;
   logic [LEN_BITS-1:0] alloc_used;
   logic                alloc_last;
   logic                idx_in_range;
   logic                used_zero;
   logic [LEN_BITS-1:0] chk_next;
   logic                last_chk;
   logic                rel_top;
   logic                check_ok;
   logic                g_signaled;
   logic                g_consume;
   logic                g_unused_after;
   logic                g_found;
   logic [SLOT_BITS-1:0] g_lowest;
   logic [LEN_BITS-1:0] g_keep;
   logic [LEN_BITS-1:0] g_count;
   logic                trim_hit;
   logic [LEN_BITS-1:0] trim_used;
   logic                gather_issue;

   assign alloc_full   = free_ff == LEN_BITS'(SLOT_COUNT);
   assign alloc_next   = free_ff + LEN_BITS'(1);
   assign alloc_used   = (alloc_next > used_ff) ? alloc_next : used_ff;
   assign alloc_last   = alloc_next == alloc_used;
   assign idx_in_range = LEN_BITS'(req_word.slot_index) < used_ff;
   assign used_zero    = used_ff == '0;
   assign chk_next     = LEN_BITS'(chk_addr_ff) + LEN_BITS'(1);
   assign last_chk     = chk_next == used_ff;
   assign rel_top      = (LEN_BITS'(idx_ff) + LEN_BITS'(1)) == used_ff;
   assign check_ok     = (op_ff == OP_SIGNAL) ? (status_rd == ST_ARMED)
                                              : (status_rd != ST_UNUSED);

   assign g_signaled     = status_rd == ST_SIGNALED;
   assign g_consume      = chk_valid_ff && (!g_signaled || out_ready);
   assign g_unused_after = g_signaled || (status_rd == ST_UNUSED);
   assign g_found        = found_ff || g_unused_after;
   assign g_lowest       = found_ff ? lowest_ff : chk_addr_ff;
   assign g_keep         = g_unused_after ? keep_ff : chk_next;
   assign g_count        = count_ff + LEN_BITS'(g_signaled);
   assign gather_issue   = live_ff && (!chk_valid_ff || g_consume);

   assign trim_hit  = status_rd != ST_UNUSED;
   assign trim_used = trim_hit ? chk_next : '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               case (req_word.opcode)
                  OP_ALLOCATE: begin
                     state_in = (alloc_full || alloc_last) ? CS_REPLY : CS_ALLOC_SCAN;
                  end
                  OP_SIGNAL, OP_RELEASE: begin
                     state_in = idx_in_range ? CS_CHECK : CS_REPLY;
                  end
                  OP_GATHER: begin
                     state_in = used_zero ? CS_REPLY : CS_GATHER;
                  end
                  default: begin
                     state_in = CS_REPLY;
                  end
               endcase
            end
         end
         CS_CHECK: begin
            if (op_ff == OP_RELEASE && check_ok && rel_top && idx_ff != '0) begin
               state_in = CS_TRIM;
            end else begin
               state_in = CS_REPLY;
            end
         end
         CS_ALLOC_SCAN: begin
            if (chk_valid_ff && (status_rd == ST_UNUSED || last_chk)) begin
               state_in = CS_REPLY;
            end
         end
         CS_TRIM: begin
            if (chk_valid_ff && (trim_hit || chk_addr_ff == '0)) begin
               state_in = CS_REPLY;
            end
         end
         CS_GATHER: begin
            if (g_consume && last_chk) begin
               state_in = CS_REPLY;
            end
         end
         CS_REPLY: begin
            if (out_ready) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      free_in      = free_ff;
      iss_in       = iss_ff;
      live_in      = live_ff;
      chk_valid_in = chk_valid_ff;
      chk_addr_in  = chk_addr_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      lowest_in    = lowest_ff;
      keep_in      = keep_ff;
      word_in      = word_ff;
      status_req   = '0;
      waiter_req   = '0;
      req_ready    = 1'b0;
      out_valid    = 1'b0;
      out_word     = '0;

      case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in               = req_word.opcode;
               idx_in              = req_word.slot_index;
               word_in             = '0;
               word_in.status_code = RSP_OK;
               word_in.any_waiting = !used_zero;
               word_in.last        = 1'b1;
               case (req_word.opcode)
                  OP_ALLOCATE: begin
                     if (alloc_full) begin
                        word_in.status_code = RSP_FULL;
                     end else begin
                        status_req.wr_en    = 1'b1;
                        status_req.wr_addr  = free_ff[SLOT_BITS-1:0];
                        status_req.wr_state = ST_ARMED;
                        waiter_req.wr_en    = 1'b1;
                        waiter_req.wr_addr  = free_ff[SLOT_BITS-1:0];
                        waiter_req.wr_data  = req_word.waiter_id;
                        used_in             = alloc_used;
                        word_in.slot_out    = free_ff[SLOT_BITS-1:0];
                        word_in.any_waiting = 1'b1;
                        if (alloc_last) begin
                           free_in = alloc_used;
                        end else begin
                           iss_in  = alloc_next;
                           live_in = 1'b1;
                        end
                     end
                  end
                  OP_SIGNAL, OP_RELEASE: begin
                     if (idx_in_range) begin
                        status_req.rd_en   = 1'b1;
                        status_req.rd_addr = req_word.slot_index;
                        chk_valid_in       = 1'b1;
                        chk_addr_in        = req_word.slot_index;
                     end else begin
                        word_in.status_code = RSP_BAD_SLOT;
                     end
                  end
                  OP_GATHER: begin
                     if (used_zero) begin
                        free_in = '0;
                     end else begin
                        iss_in    = '0;
                        live_in   = 1'b1;
                        count_in  = '0;
                        found_in  = 1'b0;
                        lowest_in = '0;
                        keep_in   = '0;
                     end
                  end
                  default: begin
                     word_in.status_code = RSP_BAD_SLOT;
                  end
               endcase
            end
         end
         CS_CHECK: begin
            chk_valid_in = 1'b0;
            if (!check_ok) begin
               word_in.status_code = RSP_BAD_SLOT;
            end else if (op_ff == OP_SIGNAL) begin
               status_req.wr_en    = 1'b1;
               status_req.wr_addr  = idx_ff;
               status_req.wr_state = ST_SIGNALED;
            end else begin
               status_req.wr_en    = 1'b1;
               status_req.wr_addr  = idx_ff;
               status_req.wr_state = ST_UNUSED;
               if (rel_top) begin
                  if (idx_ff == '0) begin
                     used_in             = '0;
                     free_in             = '0;
                     word_in.any_waiting = 1'b0;
                  end else begin
                     iss_in  = LEN_BITS'(idx_ff) - LEN_BITS'(1);
                     live_in = 1'b1;
                  end
               end
            end
         end
         CS_ALLOC_SCAN: begin
            chk_valid_in = live_ff;
            if (live_ff) begin
               status_req.rd_en   = 1'b1;
               status_req.rd_addr = iss_ff[SLOT_BITS-1:0];
               chk_addr_in        = iss_ff[SLOT_BITS-1:0];
               iss_in             = iss_ff + LEN_BITS'(1);
               live_in            = (iss_ff + LEN_BITS'(1)) < used_ff;
            end
            if (chk_valid_ff) begin
               if (status_rd == ST_UNUSED) begin
                  free_in = LEN_BITS'(chk_addr_ff);
               end else if (last_chk) begin
                  free_in = used_ff;
               end
            end
         end
         CS_TRIM: begin
            chk_valid_in = live_ff;
            if (live_ff) begin
               status_req.rd_en   = 1'b1;
               status_req.rd_addr = iss_ff[SLOT_BITS-1:0];
               chk_addr_in        = iss_ff[SLOT_BITS-1:0];
               iss_in             = iss_ff - LEN_BITS'(1);
               live_in            = iss_ff != '0;
            end
            if (chk_valid_ff && (trim_hit || chk_addr_ff == '0)) begin
               used_in             = trim_used;
               free_in             = (free_ff > trim_used) ? trim_used : free_ff;
               word_in.any_waiting = trim_used != '0;
            end
         end
         CS_GATHER: begin
            if (gather_issue) begin
               status_req.rd_en   = 1'b1;
               status_req.rd_addr = iss_ff[SLOT_BITS-1:0];
               waiter_req.rd_en   = 1'b1;
               waiter_req.rd_addr = iss_ff[SLOT_BITS-1:0];
               chk_addr_in        = iss_ff[SLOT_BITS-1:0];
               iss_in             = iss_ff + LEN_BITS'(1);
               live_in            = (iss_ff + LEN_BITS'(1)) < used_ff;
               chk_valid_in       = 1'b1;
            end else if (g_consume) begin
               chk_valid_in = 1'b0;
            end
            if (chk_valid_ff && g_signaled) begin
               out_valid            = 1'b1;
               out_word.waiter_out  = waiter_rd;
               out_word.status_code = RSP_OK;
            end
            if (g_consume) begin
               if (g_signaled) begin
                  status_req.wr_en    = 1'b1;
                  status_req.wr_addr  = chk_addr_ff;
                  status_req.wr_state = ST_UNUSED;
               end
               count_in  = g_count;
               found_in  = g_found;
               lowest_in = g_lowest;
               keep_in   = g_keep;
               if (last_chk) begin
                  used_in                = g_keep;
                  free_in                = g_found ? LEN_BITS'(g_lowest) : g_keep;
                  word_in                = '0;
                  word_in.gathered_count = g_count;
                  word_in.status_code    = RSP_OK;
                  word_in.any_waiting    = g_keep != '0;
                  word_in.last           = 1'b1;
               end
            end
         end
         CS_REPLY: begin
            out_valid = 1'b1;
            out_word  = word_ff;
         end
         default: begin
            chk_valid_in = 1'b0;
         end
      endcase

      if (state_in == CS_REPLY) begin
         chk_valid_in = 1'b0;
         live_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         used_ff      <= '0;
         free_ff      <= '0;
         live_ff      <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         free_ff      <= free_in;
         live_ff      <= live_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      iss_ff      <= iss_in;
      chk_addr_ff <= chk_addr_in;
      count_ff    <= count_in;
      found_ff    <= found_in;
      lowest_ff   <= lowest_in;
      keep_ff     <= keep_in;
      word_ff     <= word_in;
   end

endmodule
`default_nettype wire

// ----- bench/signal_slot_table_core_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Signal slot table core test
// Drives allocate, signal, release and gather words into the core, tracking
// the slot table in a local copy, and checks every response word in order
// against the words it predicts. Later runs idle both channels at random.
// ----------------------------------------------------------------------------
module signal_slot_table_core_test;
   import sst_pkg::*;

   logic clock;
   logic reset;

   sst_req_if req_ch ();
   sst_rsp_if rsp_ch ();

   signal_slot_table_core dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   slot_state_type         slot_state [SLOT_COUNT];
   logic [WAITER_BITS-1:0] slot_owner [SLOT_COUNT];
   int                     used_len;
   int                     first_free;
   rsp_word_type           pending_words [$];

   int send_gap_pct;
   int rsp_stall_pct;
   int mismatch_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void trim_length();
      while (used_len > 0 && slot_state[used_len - 1] == ST_UNUSED)
         used_len--;
   endfunction

   function automatic void predict_words(input opcode_type op,
                                         input logic [SLOT_BITS-1:0] idx,
                                         input logic [WAITER_BITS-1:0] wid);
      rsp_word_type w;
      int           i;
      int           lowest;
      int           count;
      w = '0;
      w.last = 1'b1;
      case (op)
         OP_ALLOCATE: begin
            if (first_free >= SLOT_COUNT) begin
               w.status_code = RSP_FULL;
               w.any_waiting = (used_len != 0);
            end else begin
               w.slot_out = SLOT_BITS'(first_free);
               w.any_waiting = 1'b1;
               slot_owner[first_free] = wid;
               slot_state[first_free] = ST_ARMED;
               if (first_free + 1 > used_len)
                  used_len = first_free + 1;
               i = first_free + 1;
               first_free = SLOT_COUNT;
               for (; i < SLOT_COUNT && first_free == SLOT_COUNT; i++)
                  if (slot_state[i] == ST_UNUSED)
                     first_free = i;
            end
         end
         OP_SIGNAL: begin
            if (idx >= used_len || slot_state[idx] != ST_ARMED) begin
               w.status_code = RSP_BAD_SLOT;
               w.any_waiting = (used_len != 0);
            end else begin
               slot_state[idx] = ST_SIGNALED;
               w.any_waiting = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (idx >= used_len || slot_state[idx] == ST_UNUSED) begin
               w.status_code = RSP_BAD_SLOT;
               w.any_waiting = (used_len != 0);
            end else begin
               slot_state[idx] = ST_UNUSED;
               trim_length();
               if (first_free > used_len)
                  first_free = used_len;
               w.any_waiting = (used_len != 0);
            end
         end
         default: begin
            lowest = -1;
            count = 0;
            for (i = 0; i < used_len; i++) begin
               if (slot_state[i] == ST_SIGNALED) begin
                  w = '0;
                  w.waiter_out = slot_owner[i];
                  pending_words.push_back(w);
                  slot_state[i] = ST_UNUSED;
                  count++;
               end
               if (slot_state[i] == ST_UNUSED && lowest < 0)
                  lowest = i;
            end
            trim_length();
            first_free = (lowest >= 0) ? lowest : used_len;
            w = '0;
            w.gathered_count = LEN_BITS'(count);
            w.any_waiting = (used_len != 0);
            w.last = 1'b1;
         end
      endcase
      pending_words.push_back(w);
   endfunction

   function automatic int pick_slot(input bit armed_only);
      int picks [$];
      int i;
      for (i = 0; i < used_len; i++)
         if (slot_state[i] == ST_ARMED || (!armed_only && slot_state[i] == ST_SIGNALED))
            picks.push_back(i);
      if (picks.size() == 0)
         return -1;
      return picks[$urandom_range(picks.size() - 1)];
   endfunction

   task automatic send_word(input opcode_type op, input int idx,
                            input logic [WAITER_BITS-1:0] wid);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.slot_index <= SLOT_BITS'(idx);
      req_ch.waiter_id <= wid;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_words(op, SLOT_BITS'(idx), wid);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_word(OP_SIGNAL, 0, 16'h0000);
      send_word(OP_RELEASE, 0, 16'h0000);
      send_word(OP_GATHER, 0, 16'h0000);
   endtask

   task automatic test_slot_lifecycle();
      send_word(OP_ALLOCATE, 0, 16'h0000);
      send_word(OP_ALLOCATE, 0, 16'hFFFF);
      send_word(OP_ALLOCATE, 0, 16'h5A5A);
      send_word(OP_SIGNAL, 1, 16'h0000);
      send_word(OP_SIGNAL, 1, 16'h0000);
      send_word(OP_SIGNAL, 31, 16'h0000);
      send_word(OP_RELEASE, 0, 16'h0000);
      send_word(OP_SIGNAL, 0, 16'h0000);
      send_word(OP_RELEASE, 0, 16'h0000);
      send_word(OP_SIGNAL, 2, 16'h0000);
      send_word(OP_RELEASE, 2, 16'h0000);
      send_word(OP_GATHER, 0, 16'h0000);
      send_word(OP_ALLOCATE, 31, 16'hA5C3);
      send_word(OP_SIGNAL, 0, 16'hFFFF);
      send_word(OP_GATHER, 31, 16'hFFFF);
   endtask

   task automatic test_random_traffic(input int count);
      int n;
      int r;
      int idx;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(99);
         idx = $urandom_range(SLOT_COUNT - 1);
         if (r < 35) begin
            send_word(OP_ALLOCATE, idx, WAITER_BITS'($urandom()));
         end else if (r < 65) begin
            if ($urandom_range(9) < 8 && pick_slot(1'b1) >= 0)
               idx = pick_slot(1'b1);
            send_word(OP_SIGNAL, idx, WAITER_BITS'($urandom()));
         end else if (r < 80) begin
            if ($urandom_range(9) < 8 && pick_slot(1'b0) >= 0)
               idx = pick_slot(1'b0);
            send_word(OP_RELEASE, idx, WAITER_BITS'($urandom()));
         end else if (r < 90) begin
            send_word(OP_GATHER, idx, WAITER_BITS'($urandom()));
         end else begin
            send_word(opcode_type'($urandom_range(3)), idx, WAITER_BITS'($urandom()));
         end
      end
   endtask

   task automatic test_full_table();
      int i;
      while (first_free < SLOT_COUNT)
         send_word(OP_ALLOCATE, $urandom_range(SLOT_COUNT - 1), WAITER_BITS'($urandom()));
      send_word(OP_ALLOCATE, 0, WAITER_BITS'($urandom()));
      send_word(OP_RELEASE, SLOT_COUNT - 1, WAITER_BITS'($urandom()));
      send_word(OP_ALLOCATE, 0, WAITER_BITS'($urandom()));
      for (i = 0; i < SLOT_COUNT; i++)
         send_word(OP_SIGNAL, i, WAITER_BITS'($urandom()));
      send_word(OP_GATHER, 0, 16'h0000);
      send_word(OP_GATHER, 0, 16'h0000);
   endtask

   initial begin
      rsp_word_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected word: slot %0d waiter %h count %0d status %0d any %b last %b",
                           rsp_ch.slot_out, rsp_ch.waiter_out, rsp_ch.gathered_count,
                           rsp_ch.status_code, rsp_ch.any_waiting, rsp_ch.last);
            end else begin
               want = pending_words.pop_front();
               if (rsp_ch.slot_out !== want.slot_out || rsp_ch.waiter_out !== want.waiter_out ||
                   rsp_ch.gathered_count !== want.gathered_count ||
                   rsp_ch.status_code !== want.status_code ||
                   rsp_ch.any_waiting !== want.any_waiting || rsp_ch.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Word mismatch at %0t", $realtime);
                     $display("  expected: slot %0d waiter %h count %0d status %0d any %b last %b",
                              want.slot_out, want.waiter_out, want.gathered_count,
                              want.status_code, want.any_waiting, want.last);
                     $display("  actual:   slot %0d waiter %h count %0d status %0d any %b last %b",
                              rsp_ch.slot_out, rsp_ch.waiter_out, rsp_ch.gathered_count,
                              rsp_ch.status_code, rsp_ch.any_waiting, rsp_ch.last);
                  end
               end
            end
         end
         rsp_ch.ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      #40000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int i;
      for (i = 0; i < SLOT_COUNT; i++) begin
         slot_state[i] = ST_UNUSED;
         slot_owner[i] = '0;
      end
      used_len = 0;
      first_free = 0;
      mismatch_count = 0;
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_ALLOCATE;
      req_ch.slot_index <= '0;
      req_ch.waiter_id <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_slot_lifecycle();
      test_random_traffic(45);
      wait_drained();

      send_gap_pct = 85;
      test_random_traffic(45);
      wait_drained();

      send_gap_pct = 0;
      rsp_stall_pct = 85;
      test_random_traffic(45);
      wait_drained();

      send_gap_pct = 28;
      rsp_stall_pct = 28;
      test_random_traffic(45);
      test_full_table();
      wait_drained();

      repeat (SLOT_COUNT + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_words.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/sst_pkg.sv
rtl/core/sst_if.sv
rtl/core/sst_status_mem.sv
rtl/core/sst_waiter_mem.sv
rtl/core/sst_ctrl.sv
rtl/core/signal_slot_table_core.sv
bench/signal_slot_table_core_test.sv
